// ----- rtl/core/rotate_vector_about_axis_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rotate_vector_about_axis_core checker
// Each macro expands to one labeled concurrent assertion on clk.
// ----------------------------------------------------------------------------
`ifndef ROTATE_VECTOR_ABOUT_AXIS_CORE_ASSERT_SVH
`define ROTATE_VECTOR_ABOUT_AXIS_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RVAA_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rvaa check failed in %m");

// Next-cycle implication, disabled while reset is asserted.
`define RVAA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rvaa check failed in %m");

// Plain condition that must also hold while reset is asserted.
`define RVAA_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) (cond)) \
		else $error("rvaa check failed in %m");

`endif

// ----- rtl/core/rvaa_pkg.sv -----
// ----------------------------------------------------------------------------
// rvaa_pkg
// Shared widths, constants and types of the axis-angle vector rotator.
// ----------------------------------------------------------------------------
package rvaa_pkg;

	localparam int FRACTION_BITS_DEF = 14;

	localparam int COMP_W    = 16;
	localparam int ROT_W     = 18;
	localparam int S_TDATA_W = 112;
	localparam int M_TDATA_W = 56;

	localparam int CORDIC_STEPS    = 20;
	localparam int STEPS_PER_STAGE = 2;
	localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
	localparam int STEP_IDX_W      = $clog2(CORDIC_STEPS);
	localparam int CORDIC_FRAC     = 30;
	localparam int XY_W            = 32;
	localparam int ANG_W           = 25;

	localparam logic signed [XY_W-1:0]  CORDIC_GAIN  = 32'sd652032874;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 25'sd4194304;
	localparam logic signed [ANG_W-1:0] HALF_TURN    = 25'sd8388608;

	localparam logic signed [ROT_W-1:0] ROT_MAX = 18'sh1ffff;
	localparam logic signed [ROT_W-1:0] ROT_MIN = 18'sh20000;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef comp_t [2:0] vec3_t;

	typedef struct packed {
		logic signed [XY_W-1:0]  x;
		logic signed [XY_W-1:0]  y;
		logic signed [ANG_W-1:0] a;
	} cordic_t;

	// Arctangent of 2^-i in units of 2^-24 turn.
	localparam logic signed [ANG_W-1:0] ATAN_TBL [CORDIC_STEPS] = '{
		25'sd2097152, 25'sd1238021, 25'sd654136, 25'sd332050, 25'sd166669,
		25'sd83416,   25'sd41718,   25'sd20860,  25'sd10430,  25'sd5215,
		25'sd2608,    25'sd1304,    25'sd652,    25'sd326,    25'sd163,
		25'sd81,      25'sd41,      25'sd20,     25'sd10,     25'sd5
	};

endpackage

// ----- rtl/core/rvaa_cordic.sv -----
// ----------------------------------------------------------------------------
// rvaa_cordic
// Pipelined rotation-mode CORDIC, two micro-rotations per register stage.
// ----------------------------------------------------------------------------
module rvaa_cordic (
	input  logic                                clk,
	input  logic [rvaa_pkg::CORDIC_STAGES-1:0]  en,
	input  logic signed [rvaa_pkg::ANG_W-1:0]   ang,
	input  logic                                flip_in,
	output logic signed [rvaa_pkg::XY_W-1:0]    x_out,
	output logic signed [rvaa_pkg::XY_W-1:0]    y_out,
	output logic                                flip_out
);
	import rvaa_pkg::*;

	cordic_t st_s   [CORDIC_STAGES];
	logic    flip_s [CORDIC_STAGES];

	function automatic cordic_t cordic_step(input cordic_t cur,
			input logic [STEP_IDX_W-1:0] idx);
		cordic_t nxt;
		if (!cur.a[ANG_W-1]) begin
			nxt.x = $signed(cur.x) - ($signed(cur.y) >>> idx);
			nxt.y = $signed(cur.y) + ($signed(cur.x) >>> idx);
			nxt.a = $signed(cur.a) - ATAN_TBL[idx];
		end else begin
			nxt.x = $signed(cur.x) + ($signed(cur.y) >>> idx);
			nxt.y = $signed(cur.y) - ($signed(cur.x) >>> idx);
			nxt.a = $signed(cur.a) + ATAN_TBL[idx];
		end
		return nxt;
	endfunction

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
		cordic_t cur;
		cordic_t nxt;
		logic    flip_cur;

		if (g == 0) begin : g_first
			assign cur      = {CORDIC_GAIN, {XY_W{1'b0}}, ang};
			assign flip_cur = flip_in;
		end else begin : g_next
			assign cur      = st_s[g-1];
			assign flip_cur = flip_s[g-1];
		end

		always_comb begin
			nxt = cur;
			for (int k = 0; k < STEPS_PER_STAGE; k++) begin
				nxt = cordic_step(nxt, STEP_IDX_W'(g * STEPS_PER_STAGE + k));
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) begin
				st_s[g]   <= nxt;
				flip_s[g] <= flip_cur;
			end
		end
	end

	assign x_out    = st_s[CORDIC_STAGES-1].x;
	assign y_out    = st_s[CORDIC_STAGES-1].y;
	assign flip_out = flip_s[CORDIC_STAGES-1];

endmodule

// ----- rtl/core/rotate_vector_about_axis_core.sv -----
// ----------------------------------------------------------------------------
// rotate_vector_about_axis_core
// Rotates a 3D vector about an axis by an angle with the axis-angle matrix.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat on s_axis carries a vector, a rotation axis (used as given,
// not normalized) and an angle in 1/65536 turns. Each output beat on m_axis
// carries the rotated vector, rounded and saturated to 18-bit signed values.
// Throughput is one beat per cycle while the receiver keeps m_axis_tready high.
// The 17 register stages are: angle fold, ten CORDIC stages of two iterations
// each, cosine and sine rounding with the axis products, three stages that
// build the rotation matrix, the matrix-vector products, and the summing and
// saturating output register.
// Every stage advances on its own, so empty stages fill while the output
// waits; s_axis_tready falls only when all stages hold a beat and m_axis_tready
// is low. A stalled output beat holds its data.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module rotate_vector_about_axis_core #(
	parameter int FRACTION_BITS = rvaa_pkg::FRACTION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle (16 bits each)
	input  logic [rvaa_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// rot_x, rot_y, rot_z (18 bits each), two zero bits
	output logic [rvaa_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
	import rvaa_pkg::*;

	localparam int F    = FRACTION_BITS;
	localparam int CSH  = CORDIC_FRAC - F;
	localparam int CW   = F + 3;
	localparam int OMW  = CW + 1;
	localparam int UPW  = 2 * COMP_W;
	localparam int UUW  = UPW + 1 - F;
	localparam int DW   = ((F + 2 > UUW) ? F + 2 : UUW) + 1;
	localparam int USPW = COMP_W + CW;
	localparam int USW  = USPW + 1 - F;
	localparam int DPW  = CW + DW;
	localparam int TDW  = DPW + 1 - F;
	localparam int OPW  = UUW + OMW;
	localparam int TOW  = OPW + 1 - F;
	localparam int MX1  = (TDW > TOW) ? TDW : TOW;
	localparam int MX2  = (USW > UUW) ? USW : UUW;
	localparam int MW   = ((MX1 > MX2) ? MX1 : MX2) + 1;
	localparam int PVW  = MW + COMP_W;
	localparam int SW   = PVW + 2;
	localparam int RW   = SW + 1 - F;
	localparam int NS   = CORDIC_STAGES + 7;
	localparam int I12  = CORDIC_STAGES + 1;

	localparam logic signed [XY_W:0] C_RND = (CSH > 0) ?
		(XY_W+1)'(1 << ((CSH > 0) ? CSH - 1 : 0)) : (XY_W+1)'(0);
	localparam logic signed [OMW-1:0]  ONE_OM = OMW'(1 << F);
	localparam logic signed [DW-1:0]   ONE_D  = DW'(1 << F);
	localparam logic signed [UPW:0]    H_UU   = (UPW+1)'(1 << (F - 1));
	localparam logic signed [USPW:0]   H_US   = (USPW+1)'(1 << (F - 1));
	localparam logic signed [DPW:0]    H_DG   = (DPW+1)'(1 << (F - 1));
	localparam logic signed [OPW:0]    H_OF   = (OPW+1)'(1 << (F - 1));
	localparam logic signed [SW:0]     H_SUM  = (SW+1)'(1 << (F - 1));
	localparam logic signed [RW-1:0]   R_MAX  = RW'(ROT_MAX);
	localparam logic signed [RW-1:0]   R_MIN  = RW'(ROT_MIN);

	// Stage control: a stage takes a new beat when it is empty or its
	// successor takes the one it holds.
	logic [NS-1:0] vld_q;
	logic [NS-1:0] adv;

	always_comb begin
		adv[NS-1] = !vld_q[NS-1] || m_axis_tready;
		for (int k = NS - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= s_axis_tvalid;
			end
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_axis_tready = adv[0];
	assign m_axis_tvalid = vld_q[NS-1];

	// Stage 1: fold the angle into plus or minus a quarter turn.
	logic signed [ANG_W-1:0] ang_raw;
	logic signed [ANG_W-1:0] ang_fold;
	logic                    fold_flip;
	vec3_t                   v_s1;
	vec3_t                   u_s1;
	logic signed [ANG_W-1:0] a_s1;
	logic                    flip_s1;

	always_comb begin
		ang_raw   = ANG_W'($signed({s_axis_tdata[6*COMP_W +: COMP_W], 8'h00}));
		ang_fold  = ang_raw;
		fold_flip = 1'b0;
		if (ang_raw > QUARTER_TURN) begin
			ang_fold  = ang_raw - HALF_TURN;
			fold_flip = 1'b1;
		end else if (ang_raw < -QUARTER_TURN) begin
			ang_fold  = ang_raw + HALF_TURN;
			fold_flip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			v_s1    <= s_axis_tdata[0 +: 3*COMP_W];
			u_s1    <= s_axis_tdata[3*COMP_W +: 3*COMP_W];
			a_s1    <= ang_fold;
			flip_s1 <= fold_flip;
		end
	end

	// Stages 2 to 11: CORDIC, with vector and axis carried alongside.
	logic signed [XY_W-1:0] cx;
	logic signed [XY_W-1:0] cy;
	logic                   cflip;
	vec3_t                  vcarry_s [CORDIC_STAGES];
	vec3_t                  ucarry_s [CORDIC_STAGES];

	rvaa_cordic u_cordic (
		.clk      (clk),
		.en       (adv[CORDIC_STAGES:1]),
		.ang      (a_s1),
		.flip_in  (flip_s1),
		.x_out    (cx),
		.y_out    (cy),
		.flip_out (cflip)
	);

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_carry
		if (g == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv[1]) begin
					vcarry_s[0] <= v_s1;
					ucarry_s[0] <= u_s1;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv[g+1]) begin
					vcarry_s[g] <= vcarry_s[g-1];
					ucarry_s[g] <= ucarry_s[g-1];
				end
			end
		end
	end

	// Stage 12: cosine and sine at F fraction bits, axis products.
	logic signed [XY_W-1:0] cx_fl;
	logic signed [XY_W-1:0] cy_fl;
	logic signed [XY_W:0]   cx_rnd;
	logic signed [XY_W:0]   cy_rnd;
	logic signed [CW-1:0]   c_nxt;
	logic signed [CW-1:0]   s_nxt;
	vec3_t                  v_c;
	vec3_t                  u_c;

	logic signed [CW-1:0]   c_s12;
	logic signed [CW-1:0]   sn_s12;
	logic signed [OMW-1:0]  omc_s12;
	logic signed [UPW-1:0]  uud_raw_s12 [3];
	logic signed [UPW-1:0]  uuo_raw_s12 [3];
	vec3_t                  v_s12;
	vec3_t                  u_s12;

	assign v_c = vcarry_s[CORDIC_STAGES-1];
	assign u_c = ucarry_s[CORDIC_STAGES-1];

	always_comb begin
		cx_fl  = cflip ? -cx : cx;
		cy_fl  = cflip ? -cy : cy;
		cx_rnd = (XY_W+1)'(cx_fl) + C_RND;
		cy_rnd = (XY_W+1)'(cy_fl) + C_RND;
		c_nxt  = cx_rnd[XY_W:CSH];
		s_nxt  = cy_rnd[XY_W:CSH];
	end

	always_ff @(posedge clk) begin
		if (adv[I12]) begin
			c_s12          <= c_nxt;
			sn_s12         <= s_nxt;
			omc_s12        <= ONE_OM - OMW'(c_nxt);
			for (int i = 0; i < 3; i++) begin
				uud_raw_s12[i] <= $signed(u_c[i]) * $signed(u_c[i]);
			end
			uuo_raw_s12[0] <= $signed(u_c[0]) * $signed(u_c[1]);
			uuo_raw_s12[1] <= $signed(u_c[0]) * $signed(u_c[2]);
			uuo_raw_s12[2] <= $signed(u_c[1]) * $signed(u_c[2]);
			v_s12          <= v_c;
			u_s12          <= u_c;
		end
	end

	// Stage 13: rounded axis products, one minus their diagonal, axis times sine.
	logic signed [UPW:0]    uud_t [3];
	logic signed [UPW:0]    uuo_t [3];
	logic signed [UUW-1:0]  uud_n [3];

	logic signed [UUW-1:0]  uud_s13    [3];
	logic signed [UUW-1:0]  uuo_s13    [3];
	logic signed [DW-1:0]   omuu_s13   [3];
	logic signed [USPW-1:0] us_raw_s13 [3];
	logic signed [CW-1:0]   c_s13;
	logic signed [OMW-1:0]  omc_s13;
	vec3_t                  v_s13;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			uud_t[i] = (UPW+1)'(uud_raw_s12[i]) + H_UU;
			uuo_t[i] = (UPW+1)'(uuo_raw_s12[i]) + H_UU;
			uud_n[i] = uud_t[i][UPW:F];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[I12+1]) begin
			for (int i = 0; i < 3; i++) begin
				uud_s13[i]    <= uud_n[i];
				uuo_s13[i]    <= uuo_t[i][UPW:F];
				omuu_s13[i]   <= ONE_D - DW'(uud_n[i]);
				us_raw_s13[i] <= $signed(u_s12[i]) * sn_s12;
			end
			c_s13   <= c_s12;
			omc_s13 <= omc_s12;
			v_s13   <= v_s12;
		end
	end

	// Stage 14: products with the cosine and with one minus the cosine.
	logic signed [USPW:0]   us_t [3];

	logic signed [USW-1:0]  us_s14     [3];
	logic signed [DPW-1:0]  dg_raw_s14 [3];
	logic signed [OPW-1:0]  of_raw_s14 [3];
	logic signed [UUW-1:0]  uud_s14    [3];
	vec3_t                  v_s14;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			us_t[i] = (USPW+1)'(us_raw_s13[i]) + H_US;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[I12+2]) begin
			for (int i = 0; i < 3; i++) begin
				us_s14[i]     <= us_t[i][USPW:F];
				dg_raw_s14[i] <= c_s13 * omuu_s13[i];
				of_raw_s14[i] <= uuo_s13[i] * omc_s13;
				uud_s14[i]    <= uud_s13[i];
			end
			v_s14 <= v_s13;
		end
	end

	// Stage 15: matrix entries.
	logic signed [DPW:0]    dg_t [3];
	logic signed [OPW:0]    of_t [3];
	logic signed [TDW-1:0]  td   [3];
	logic signed [TOW-1:0]  tof  [3];
	logic signed [MW-1:0]   m_nxt [3][3];

	logic signed [MW-1:0]   m_s15 [3][3];
	vec3_t                  v_s15;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dg_t[i] = (DPW+1)'(dg_raw_s14[i]) + H_DG;
			of_t[i] = (OPW+1)'(of_raw_s14[i]) + H_OF;
			td[i]   = dg_t[i][DPW:F];
			tof[i]  = of_t[i][OPW:F];
			m_nxt[i][i] = MW'(uud_s14[i]) + MW'(td[i]);
		end
		m_nxt[0][1] = MW'(tof[0]) - MW'(us_s14[2]);
		m_nxt[0][2] = MW'(tof[1]) + MW'(us_s14[1]);
		m_nxt[1][0] = MW'(tof[0]) + MW'(us_s14[2]);
		m_nxt[1][2] = MW'(tof[2]) - MW'(us_s14[0]);
		m_nxt[2][0] = MW'(tof[1]) - MW'(us_s14[1]);
		m_nxt[2][1] = MW'(tof[2]) + MW'(us_s14[0]);
	end

	always_ff @(posedge clk) begin
		if (adv[I12+3]) begin
			m_s15 <= m_nxt;
			v_s15 <= v_s14;
		end
	end

	// Stage 16: matrix times vector, one product per entry.
	logic signed [PVW-1:0]  p_s16 [3][3];

	always_ff @(posedge clk) begin
		if (adv[I12+4]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s16[i][j] <= m_s15[i][j] * $signed(v_s15[j]);
				end
			end
		end
	end

	// Stage 17: row sums, rounding and saturation into the output register.
	logic signed [SW-1:0]    row_sum [3];
	logic signed [SW:0]      row_t   [3];
	logic signed [RW-1:0]    row_r   [3];
	logic signed [ROT_W-1:0] rot_nxt [3];

	logic signed [ROT_W-1:0] rot_s17 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			row_sum[i] = SW'(p_s16[i][0]) + SW'(p_s16[i][1]) + SW'(p_s16[i][2]);
			row_t[i]   = (SW+1)'(row_sum[i]) + H_SUM;
			row_r[i]   = row_t[i][SW:F];
			if (row_r[i] > R_MAX) begin
				rot_nxt[i] = ROT_MAX;
			end else if (row_r[i] < R_MIN) begin
				rot_nxt[i] = ROT_MIN;
			end else begin
				rot_nxt[i] = row_r[i][ROT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NS-1]) begin
			rot_s17 <= rot_nxt;
		end
	end

	assign m_axis_tdata = {(M_TDATA_W - 3*ROT_W)'(0), rot_s17[2], rot_s17[1], rot_s17[0]};

endmodule

// ----- rtl/core/rvaa_checker.sv -----
// ----------------------------------------------------------------------------
// rvaa_checker
// Port-level checks of rotate_vector_about_axis_core, bound to the top level.
// ----------------------------------------------------------------------------
`include "rotate_vector_about_axis_core_assert.svh"

module rvaa_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [rvaa_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
	import rvaa_pkg::*;

	// No output beat can be pending while reset is held.
	`RVAA_ASSERT_ALWAYS(a_reset_empty, arst_n || !m_axis_tvalid)

	// A stalled output beat stays and keeps its data.
	`RVAA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// When the last stage is free or drains, every stage can advance.
	`RVAA_ASSERT(a_in_ready, !m_axis_tvalid || m_axis_tready, s_axis_tready)

	// The padding above the three results is always zero.
	`RVAA_ASSERT(a_pad_zero, m_axis_tvalid, m_axis_tdata[M_TDATA_W-1:3*ROT_W] == '0)

endmodule

bind rotate_vector_about_axis_core rvaa_checker u_rvaa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
